FILE: src/srde_pkg.sv
// ----------------------------------------------------------------------------
// srde_pkg
// Shared constants for the signed radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

   localparam int VALUE_W        = 32;
   localparam int CHAR_W         = 8;
   localparam int RADIX_W        = 5;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_INDEX_W    = 2;
   localparam int ALPHA_N        = 16;
   localparam int ALPHA_IDX_W    = 4;
   localparam int MAX_DIGITS     = 32;
   localparam int DIG_IDX_W      = $clog2(MAX_DIGITS);
   localparam int DIG_CNT_W      = DIG_IDX_W + 1;
   localparam int DEF_MAX_RADIX  = 16;
   localparam int BITS_PER_CYCLE = 8;
   localparam int DIV_STEPS      = VALUE_W / BITS_PER_CYCLE;
   localparam int DIV_STEP_W     = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] REG_RADIX      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_HIGH = 2'd2;

   localparam logic [RADIX_W-1:0]    RADIX_RST      = 5'd10;
   localparam logic [CSR_DATA_W-1:0] ALPHA_LOW_RST  = 64'h3736353433323130;
   localparam logic [CSR_DATA_W-1:0] ALPHA_HIGH_RST = 64'h0000000000003938;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;

endpackage

FILE: src/signed_radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter
// Converts a signed 32-bit value to characters in a configured radix.
// ----------------------------------------------------------------------------
//  channel  dir  ports                               transfer
//  req      in   req_valid/req_ready, req_value      valid & ready
//  rsp      out  rsp_valid/rsp_ready, rsp_character, valid & ready
//                rsp_last_char
//  csr      in   csr_we, csr_index, csr_wdata        csr_we
//
//  Steps: check state, then per digit the shared divide step (8 quotient bits
//  a cycle), an optional minus sign, then one digit store read and one emit
//  per digit.
//  Invalid alphabet: item is dropped in the check state, no transfer on rsp.
//  req_ready is high only when idle; rsp stalls hold the emit sequence.
//  reset is synchronous; the digit store is not cleared.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter #(
   parameter int MAX_RADIX = srde_pkg::DEF_MAX_RADIX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [srde_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [srde_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                rsp_last_char,
   input  logic                                csr_we,
   input  logic [srde_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srde_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import srde_pkg::*;

   localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
   localparam int REM_W   = DIGIT_W + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_RD    = 3'd4;
   localparam logic [2:0] ST_LOAD  = 3'd5;

   logic [RADIX_W-1:0]         radix_ff;
   logic [CSR_DATA_W-1:0]      alpha_lo_ff;
   logic [CSR_DATA_W-1:0]      alpha_hi_ff;
   logic [2*CSR_DATA_W-1:0]    alpha;

   logic [2:0]                 state_ff, state_in;
   logic [VALUE_W-1:0]         mag_ff, mag_in;
   logic [DIGIT_W-1:0]         rem_ff, rem_in;
   logic                       neg_ff, neg_in;
   logic [DIG_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIV_STEP_W-1:0]      step_ff, step_in;

   logic                       out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]          out_char_ff, out_char_in;
   logic                       out_last_ff, out_last_in;

   logic [DIGIT_W-1:0]         dig_mem [MAX_DIGITS];
   logic [DIGIT_W-1:0]         rd_data_ff;
   logic [DIG_IDX_W-1:0]       rd_addr;
   logic                       dig_we;

   logic                       alpha_ok;
   logic [VALUE_W-1:0]         div_mag;
   logic [DIGIT_W-1:0]         div_rem;
   logic                       out_free;
   logic [CHAR_W-1:0]          digit_char;

   assign alpha = {alpha_hi_ff, alpha_lo_ff};

   // alphabet check: range, forbidden characters, duplicates
   always_comb begin
      logic [CHAR_W-1:0] ci;
      alpha_ok = (radix_ff >= RADIX_W'(2)) && (radix_ff <= RADIX_W'(MAX_RADIX));
      for (int i = 0; i < ALPHA_N; i++) begin
         ci = alpha[i*CHAR_W +: CHAR_W];
         if (RADIX_W'(i) < radix_ff) begin
            if (ci == CHAR_PLUS || ci == CHAR_MINUS || ci == CHAR_SPACE ||
                ci == CHAR_TAB) begin
               alpha_ok = 1'b0;
            end
            for (int j = i + 1; j < ALPHA_N; j++) begin
               if (RADIX_W'(j) < radix_ff && alpha[j*CHAR_W +: CHAR_W] == ci) begin
                  alpha_ok = 1'b0;
               end
            end
         end
      end
   end

   // shared restoring divide step, BITS_PER_CYCLE quotient bits a cycle
   always_comb begin
      logic [REM_W-1:0] r;
      r       = '0;
      div_mag = mag_ff;
      div_rem = rem_ff;
      for (int k = 0; k < BITS_PER_CYCLE; k++) begin
         r       = {div_rem, div_mag[VALUE_W-1]};
         div_mag = {div_mag[VALUE_W-2:0], 1'b0};
         if (r >= radix_ff[REM_W-1:0]) begin
            r          = r - radix_ff[REM_W-1:0];
            div_mag[0] = 1'b1;
         end
         div_rem = r[DIGIT_W-1:0];
      end
   end

   assign out_free   = !out_valid_ff || rsp_ready;
   assign rd_addr    = DIG_IDX_W'(cnt_ff - DIG_CNT_W'(1));
   assign digit_char = alpha[{ALPHA_IDX_W'(rd_data_ff), 3'b000} +: CHAR_W];

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      dig_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_in   = req_value;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            neg_in  = mag_ff[VALUE_W-1];
            mag_in  = mag_ff[VALUE_W-1] ? (VALUE_W'(0) - mag_ff) : mag_ff;
            rem_in  = '0;
            cnt_in  = '0;
            step_in = '0;
            state_in = alpha_ok ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            mag_in  = div_mag;
            rem_in  = div_rem;
            step_in = step_ff + DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) begin
               dig_we = 1'b1;
               rem_in = '0;
               cnt_in = cnt_ff + DIG_CNT_W'(1);
               if (div_mag == '0 || cnt_ff == DIG_CNT_W'(MAX_DIGITS - 1)) begin
                  state_in = neg_ff ? ST_SIGN : ST_RD;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = digit_char;
               out_last_in  = (cnt_ff == DIG_CNT_W'(1));
               cnt_in       = cnt_ff - DIG_CNT_W'(1);
               state_in     = (cnt_ff == DIG_CNT_W'(1)) ? ST_IDLE : ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dig_we) begin
         dig_mem[cnt_ff[DIG_IDX_W-1:0]] <= div_rem;
      end
      rd_data_ff <= dig_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RST;
         alpha_lo_ff  <= ALPHA_LOW_RST;
         alpha_hi_ff  <= ALPHA_HIGH_RST;
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         step_ff      <= '0;
         mag_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_RADIX:      radix_ff    <= csr_wdata[RADIX_W-1:0];
               REG_ALPHA_LOW:  alpha_lo_ff <= csr_wdata;
               REG_ALPHA_HIGH: alpha_hi_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         mag_ff       <= mag_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

FILE: src/srde_checker.sv
// ----------------------------------------------------------------------------
// srde_checker
// Port-level checks for the signed radix digit emitter, bound to the top.
// ----------------------------------------------------------------------------
module srde_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [srde_pkg::VALUE_W-1:0] req_value,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [srde_pkg::CHAR_W-1:0]         rsp_character,
   input logic                                rsp_last_char
);
   import srde_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_character) && $stable(rsp_last_char))
      else $error("rsp changed while stalled");

   // one item at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a transfer");

   // idle and empty after reset
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // the sign never ends a number
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last_char)
      else $error("minus sign marked last");

   // a waiting request keeps its value
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_value))
      else $error("req changed while waiting");

endmodule

bind signed_radix_digit_emitter srde_checker u_srde_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_value     (req_value),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_character (rsp_character),
   .rsp_last_char (rsp_last_char)
);
